// ----- hw/rtl/flog2_pkg.sv -----
package flog2_pkg;

    // Field widths
    localparam int VAL_W       = 32;
    localparam int LZ_W        = 5;
    localparam int IDX_W       = 6;
    localparam int RECIP_W     = 8;
    localparam int RSCALE_W    = 10;
    localparam int TAB_W       = 32;
    localparam int TAB_SHIFT   = 29;
    localparam int RES_W       = 37;
    localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Fixed-point datapath widths (Q40 signed for dx and the polynomial)
    localparam int DX_FRAC  = 40;
    localparam int PROD_W   = VAL_W + RSCALE_W;
    localparam int BASE_W   = LZ_W + IDX_W + TAB_SHIFT + 1;
    localparam int DX_W     = PROD_W + 1;
    localparam int A1_W     = DX_W + 1;
    localparam int C0_W     = 40;
    localparam int SQ_W     = A1_W + DX_W - DX_FRAC + 1;
    localparam int INNER_W  = SQ_W + 1;
    localparam int LIN_W    = DX_W + C0_W - DX_FRAC + 1;
    localparam int POLY_W   = LIN_W + INNER_W - DX_FRAC + 1;
    localparam int SUM_W    = POLY_W + 1;

    // Pipeline depth of one rounding multiplier
    localparam int MUL_LAT  = 4;

    localparam logic [RSCALE_W-1:0] RECIP_BIAS = RSCALE_W'(257);
    localparam logic [BASE_W-1:0]   BASE_BIAS  = BASE_W'(1) << TAB_SHIFT;

    // Polynomial coefficients, nearest Q40
    localparam logic signed [63:0] POLY_C0_64 = 64'sd515899381640;
    localparam logic signed [63:0] POLY_C1_64 = -64'sd1690088650462;
    localparam logic signed [63:0] POLY_C2_64 = 64'sd3380719093183;
    localparam logic signed [63:0] DX_ONE_64  = 64'sd1 <<< DX_FRAC;

    localparam logic signed [C0_W-1:0]    POLY_C0   = C0_W'(POLY_C0_64);
    localparam logic signed [INNER_W-1:0] POLY_C2   = INNER_W'(POLY_C2_64);
    localparam logic signed [DX_W-1:0]    DX_ONE    = DX_W'(DX_ONE_64);
    // dx + C1 taken straight from the product: prod - 1.0 + C1
    localparam logic signed [A1_W-1:0]    A1_OFFSET = A1_W'(POLY_C1_64 - DX_ONE_64);

    // Normalizer to polynomial section
    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [PROD_W-1:0] prod;
        logic [BASE_W-1:0] base;
    } flog2_norm_t;

    // One result
    typedef struct packed {
        logic             zero_input;
        logic [RES_W-1:0] log2_result;
    } flog2_res_t;

    localparam logic [RECIP_W-1:0] RECIP_TAB [1 << IDX_W] = '{
        8'd255, 8'd248, 8'd240, 8'd233, 8'd225, 8'd218, 8'd212, 8'd205,
        8'd199, 8'd192, 8'd186, 8'd180, 8'd175, 8'd169, 8'd164, 8'd158,
        8'd153, 8'd148, 8'd143, 8'd138, 8'd134, 8'd129, 8'd125, 8'd120,
        8'd116, 8'd112, 8'd108, 8'd104, 8'd100, 8'd96,  8'd92,  8'd88,
        8'd85,  8'd81,  8'd78,  8'd74,  8'd71,  8'd68,  8'd65,  8'd62,
        8'd59,  8'd56,  8'd53,  8'd50,  8'd47,  8'd44,  8'd41,  8'd39,
        8'd36,  8'd33,  8'd31,  8'd28,  8'd26,  8'd24,  8'd21,  8'd19,
        8'd17,  8'd14,  8'd12,  8'd10,  8'd8,   8'd6,   8'd4,   8'd2
    };

    // Segment offsets, scale 2^35
    localparam logic [TAB_W-1:0] BASE_TAB [1 << IDX_W] = '{
        32'd536870912,  32'd682398916,  32'd937091716,  32'd1103362014,
        32'd1382486880, 32'd1570799997, 32'd1664072623, 32'd1872638678,
        32'd1983759008, 32'd2213741774, 32'd2343750303, 32'd2482852922,
        32'd2516421264, 32'd2672857097, 32'd2721242383, 32'd2895923748,
        32'd2959916243, 32'd3031281479, 32'd3110202637, 32'd3196869810,
        32'd3164538868, 32'd3265651333, 32'd3245145759, 32'd3361388697,
        32'd3353276123, 32'd3350864557, 32'd3354278275, 32'd3363645664,
        32'd3379099398, 32'd3400776639, 32'd3428819239, 32'd3463373953,
        32'd3359437008, 32'd3405756636, 32'd3310825865, 32'd3369405046,
        32'd3283863116, 32'd3202468219, 32'd3125297270, 32'd3052429348,
        32'd2983945771, 32'd2919930186, 32'd2860468654, 32'd2805649749,
        32'd2755564656, 32'd2710307269, 32'd2669974306, 32'd2466913573,
        32'd2435010941, 32'd2408305329, 32'd2214485088, 32'd2196683046,
        32'd2008902480, 32'd1823597751, 32'd1818795892, 32'd1639837179,
        32'd1463481486, 32'd1472347728, 32'd1302668303, 32'd1135729139,
        32'd971571443,  32'd810237358,  32'd651769995,  32'd496213457
    };

endpackage

// ----- hw/rtl/flog2_mul.sv -----
// Signed Q40 x Q40 -> Q40 multiplier, magnitude rounded half away from zero.
// Four stages: magnitude, two partial products, sum with rounding, sign.
module flog2_mul
    import flog2_pkg::*;
#(
    parameter int A_W = 44,
    parameter int B_W = 43
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [A_W-1:0]             a,
    input  logic signed [B_W-1:0]             b,
    output logic signed [A_W+B_W-DX_FRAC:0]   p
);

    localparam int BL_W = B_W / 2;
    localparam int BH_W = B_W - BL_W;
    localparam int LO_W = A_W + BL_W;
    localparam int HI_W = A_W + BH_W;
    localparam int S_W  = A_W + B_W + 1;
    localparam int R_W  = A_W + B_W - DX_FRAC + 1;
    localparam logic [S_W-1:0] ROUND = S_W'(1) << (DX_FRAC - 1);

    logic [A_W-1:0]         a_mag_reg;
    logic [B_W-1:0]         b_mag_reg;
    logic                   neg1_reg;
    logic [LO_W-1:0]        pp_lo_reg;
    logic [HI_W-1:0]        pp_hi_reg;
    logic                   neg2_reg;
    logic [S_W-1:0]         sum_reg;
    logic                   neg3_reg;
    logic [R_W-1:0]         mag;
    logic signed [R_W-1:0]  p_reg;

    assign mag = sum_reg[S_W-1:DX_FRAC];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitudes and product sign
            a_mag_reg <= a[A_W-1] ? A_W'(-a) : A_W'(a);
            b_mag_reg <= b[B_W-1] ? B_W'(-b) : B_W'(b);
            neg1_reg  <= a[A_W-1] ^ b[B_W-1];
            // split partial products
            pp_lo_reg <= LO_W'(a_mag_reg) * LO_W'(b_mag_reg[BL_W-1:0]);
            pp_hi_reg <= HI_W'(a_mag_reg) * HI_W'(b_mag_reg[B_W-1:BL_W]);
            neg2_reg  <= neg1_reg;
            // recombine and add half an LSB
            sum_reg   <= S_W'(pp_lo_reg) + (S_W'(pp_hi_reg) << BL_W) + ROUND;
            neg3_reg  <= neg2_reg;
            // drop fraction, restore sign
            p_reg     <= neg3_reg ? $signed(-mag) : $signed(mag);
        end
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/flog2_norm.sv -----
// Front end: leading-zero count and normalize, table lookup,
// reduced-argument product and segment base.
module flog2_norm
    import flog2_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [VAL_W-1:0] value,
    output flog2_norm_t      norm
);

    logic [LZ_W-1:0]     lz_next;
    logic [VAL_W-1:0]    m_next;
    logic [IDX_W-1:0]    idx;
    logic [RSCALE_W-1:0] rscale_next;
    logic [PROD_W-1:0]   prod_next;
    logic [BASE_W-1:0]   base_next;

    logic                s1_valid_reg;
    logic                s1_zero_reg;
    logic [LZ_W-1:0]     s1_lz_reg;
    logic [VAL_W-1:0]    s1_m_reg;

    logic                s2_valid_reg;
    logic                s2_zero_reg;
    logic [LZ_W-1:0]     s2_lz_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    logic [VAL_W-1:0]    s2_m_reg;
    logic [RSCALE_W-1:0] s2_rscale_reg;
    logic [TAB_W-1:0]    s2_tab_reg;

    logic                s3_valid_reg;
    logic                s3_zero_reg;
    logic [PROD_W-1:0]   s3_prod_reg;
    logic [BASE_W-1:0]   s3_base_reg;

    // Binary-search leading-zero count, shifting as it goes
    always_comb
    begin
        lz_next = '0;
        m_next  = value;
        for (int k = LZ_W - 1; k >= 0; k--)
        begin
            if ((m_next >> (VAL_W - (1 << k))) == '0)
            begin
                m_next     = m_next << (1 << k);
                lz_next[k] = 1'b1;
            end
        end
    end

    // Top mantissa bits below the leading one pick the segment
    assign idx         = s1_m_reg[VAL_W-2 -: IDX_W];
    assign rscale_next = RSCALE_W'(RECIP_TAB[idx]) + RECIP_BIAS;

    // m * (recip + 257), and (31 - lz) * 2^35 + idx * 2^29 - 2^29 + table
    assign prod_next = PROD_W'(s2_m_reg) * PROD_W'(s2_rscale_reg);
    assign base_next = BASE_W'({~s2_lz_reg, s2_idx_reg, {TAB_SHIFT{1'b0}}})
                     + BASE_W'(s2_tab_reg) - BASE_BIAS;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_zero_reg   <= (value == '0);
            s1_lz_reg     <= lz_next;
            s1_m_reg      <= m_next;

            s2_zero_reg   <= s1_zero_reg;
            s2_lz_reg     <= s1_lz_reg;
            s2_idx_reg    <= idx;
            s2_m_reg      <= s1_m_reg;
            s2_rscale_reg <= rscale_next;
            s2_tab_reg    <= BASE_TAB[idx];

            s3_zero_reg   <= s2_zero_reg;
            s3_prod_reg   <= prod_next;
            s3_base_reg   <= base_next;
        end
    end

    assign norm.valid = s3_valid_reg;
    assign norm.zero  = s3_zero_reg;
    assign norm.prod  = s3_prod_reg;
    assign norm.base  = s3_base_reg;

endmodule

// ----- hw/rtl/fast_log2_table_poly.sv -----
// log2 of a 32-bit unsigned integer, unsigned fixed point with OUT_FRAC_BITS fraction bits.
// Pipeline: 3 front-end stages, 1 setup, two 4-stage multipliers with an add between,
// 1 sum stage, output register.
// Throughput: one request per cycle while the skid is empty; widest partial product is 44x25.
// A skid register behind the output keeps intake open until it fills during an output stall.
// Reset clears the valid bits, output and skid valid too; data registers are not reset.
module fast_log2_table_poly
    import flog2_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [36:0] log2_result, rest zero
    output logic                   m_axis_tuser    // [0] zero_input
);

    localparam int SHIFT    = DX_FRAC - OUT_FRAC_BITS;
    localparam int SIDE_LEN = 2 * MUL_LAT + 1;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

    logic                        en;
    flog2_norm_t                 norm;

    logic                        s4_valid_reg;
    logic                        s4_zero_reg;
    logic [BASE_W-1:0]           s4_base_reg;
    logic signed [DX_W-1:0]      s4_dx_reg;
    logic signed [A1_W-1:0]      s4_a1_reg;

    logic                        side_valid_reg [SIDE_LEN];
    logic                        side_zero_reg  [SIDE_LEN];
    logic [BASE_W-1:0]           side_base_reg  [SIDE_LEN];

    logic signed [SQ_W-1:0]      sq;
    logic signed [LIN_W-1:0]     lin;
    logic signed [INNER_W-1:0]   inner_reg;
    logic signed [LIN_W-1:0]     lin_reg;
    logic signed [POLY_W-1:0]    poly;

    logic signed [SUM_W-1:0]     sum_next;
    logic                        s14_valid_reg;
    logic                        s14_zero_reg;
    logic signed [SUM_W-1:0]     s14_sum_reg;

    logic [SUM_W-1:0]            shifted;
    flog2_res_t                  res;
    logic                        incoming;
    logic                        out_take;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        skid_valid_reg;
    logic                        skid_valid_next;
    flog2_res_t                  out_res_reg;
    flog2_res_t                  skid_res_reg;

    // Whole pipeline moves unless the skid register is occupied
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    flog2_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .value    (s_axis_tdata[VAL_W-1:0]),
        .norm     (norm)
    );

    // (dx + C1) * dx
    flog2_mul #(.A_W(A1_W), .B_W(DX_W)) u_mul_sq (
        .clk (clk),
        .en  (en),
        .a   (s4_a1_reg),
        .b   (s4_dx_reg),
        .p   (sq)
    );

    // dx * C0
    flog2_mul #(.A_W(DX_W), .B_W(C0_W)) u_mul_lin (
        .clk (clk),
        .en  (en),
        .a   (s4_dx_reg),
        .b   (POLY_C0),
        .p   (lin)
    );

    // lin * inner
    flog2_mul #(.A_W(LIN_W), .B_W(INNER_W)) u_mul_poly (
        .clk (clk),
        .en  (en),
        .a   (lin_reg),
        .b   (inner_reg),
        .p   (poly)
    );

    // Final sum with the output rounding half folded in
    assign sum_next = $signed(SUM_W'({side_base_reg[SIDE_LEN-1], 5'b0}))
                    + SUM_W'(poly) + HALF;

    // Clamp negative to zero, drop fraction bits, saturate
    assign shifted = $unsigned(s14_sum_reg) >> SHIFT;

    always_comb
    begin
        res.zero_input  = s14_zero_reg;
        res.log2_result = shifted[RES_W-1:0];
        if (s14_zero_reg || s14_sum_reg[SUM_W-1])
        begin
            res.log2_result = '0;
        end
        else if (|shifted[SUM_W-1:RES_W])
        begin
            res.log2_result = '1;
        end
    end

    // Valid bits through the polynomial section
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s14_valid_reg <= 1'b0;
            for (int i = 0; i < SIDE_LEN; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s4_valid_reg      <= norm.valid;
            side_valid_reg[0] <= s4_valid_reg;
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
            s14_valid_reg <= side_valid_reg[SIDE_LEN-1];
        end
    end

    // Polynomial section payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_zero_reg <= norm.zero;
            s4_base_reg <= norm.base;
            s4_dx_reg   <= $signed(DX_W'(norm.prod)) - DX_ONE;
            s4_a1_reg   <= $signed(A1_W'(norm.prod)) + A1_OFFSET;

            side_zero_reg[0] <= s4_zero_reg;
            side_base_reg[0] <= s4_base_reg;
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                side_zero_reg[i] <= side_zero_reg[i-1];
                side_base_reg[i] <= side_base_reg[i-1];
            end

            inner_reg <= INNER_W'(sq) + POLY_C2;
            lin_reg   <= lin;

            s14_zero_reg <= side_zero_reg[SIDE_LEN-1];
            s14_sum_reg  <= sum_next;
        end
    end

    // Output register with skid
    assign incoming        = en && s14_valid_reg;
    assign out_take        = !out_valid_reg || m_axis_tready;
    assign out_valid_next  = out_take ? (skid_valid_reg || incoming) : 1'b1;
    assign skid_valid_next = out_take ? 1'b0 : (skid_valid_reg || incoming);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end
        else if (incoming)
        begin
            skid_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_res_reg.log2_result);
    assign m_axis_tuser  = out_res_reg.zero_input;

    // Skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register occupied while output register empty");

    // Skid drains on the first accepted output
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_axis_tready) |=> !skid_valid_reg)
        else $error("skid register not drained after output accept");

    // A result arriving behind a stalled output is caught by the skid
    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && incoming) |=> skid_valid_reg)
        else $error("result lost during output stall");

    // Zero input always yields a zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero input produced nonzero result");

endmodule
